// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers, clocked on clk_i and disabled during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg
// shared types and constants of the timer to sample position unit
// ----------------------------------------------------------------------------
package tsp_pkg;

  // field widths
  localparam int unsigned TimerW   = 16;
  localparam int unsigned CpsW     = 26;
  localparam int unsigned DataW    = 32;
  localparam int unsigned FuncW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  // ticks are scaled by 1024
  localparam int unsigned TickShift = 10;
  // radix-2 divider
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  // request kinds
  localparam logic [FuncW-1:0] FUNC_QUERY    = 2'd0;
  localparam logic [FuncW-1:0] FUNC_UPDATE   = 2'd1;
  localparam logic [FuncW-1:0] FUNC_LEFTOVER = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_STREAM_ACTIVE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_AUTO_MODE     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_AUTO_PERIOD   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_CLOCKS        = 2'd3;

  localparam logic [CpsW-1:0] CLOCKS_RESET = 26'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } seq_state_e;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/timer_to_sample_position_unit.sv =====
// ----------------------------------------------------------------------------
// timer_to_sample_position_unit
// turns elapsed timer ticks into audio sample counts with a fractional carry
// ----------------------------------------------------------------------------
//  channel   | direction | content
//  s_axis    | in        | tuser: func; tdata: timer_value, leftover_samples
//  m_axis    | out       | tdata: sample_count
//  cfg       | in        | write-only registers, index 0..3
//
//  while the stream is active, update requests and non-auto query requests use
//  the shared radix-2 divider: it loads at acceptance, runs 32 steps, then the
//  result is finished and emitted. leftover requests multiply, accumulate, emit.
//  s_axis_tready is high only while the sequencer is idle; a result waiting
//  on m_axis does not stop the next request, only its own emit.
//  reset clears the control and block state and loads the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module timer_to_sample_position_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [tsp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [tsp_pkg::CpsW-1:0]          cfg_data_i,
  // requests
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,  // timer_value, leftover_samples
  input  logic [tsp_pkg::FuncW-1:0]         s_axis_tuser,  // func
  // results
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tsp_pkg::DataW-1:0]         m_axis_tdata   // sample_count
);

  // configuration registers
  logic                        active_q;
  logic                        auto_q;
  logic [tsp_pkg::TimerW-1:0]  period_q;
  logic [tsp_pkg::CpsW-1:0]    clocks_q;

  // block state
  logic [tsp_pkg::TimerW-1:0]  prev_q, prev_d;
  logic [tsp_pkg::DataW-1:0]   frac_q, frac_d;
  logic [tsp_pkg::DataW-1:0]   total_q, total_d;

  // request and result holding
  tsp_pkg::seq_state_e         state_q, state_d;
  logic [tsp_pkg::FuncW-1:0]   func_q, func_d;
  logic [tsp_pkg::TimerW-1:0]  timer_q, timer_d;
  logic [tsp_pkg::TimerW-1:0]  left_q, left_d;
  logic [tsp_pkg::DataW-1:0]   prod_q, prod_d;
  logic [tsp_pkg::DataW-1:0]   res_q, res_d;
  logic                        out_valid_q, out_valid_d;
  logic [tsp_pkg::DataW-1:0]   out_data_q, out_data_d;

  logic [tsp_pkg::FuncW-1:0]   in_func;
  logic [tsp_pkg::TimerW-1:0]  in_timer;
  logic [tsp_pkg::TimerW-1:0]  in_left;
  logic                        in_acc;
  logic [tsp_pkg::TimerW-1:0]  ticks;
  logic [tsp_pkg::DataW-1:0]   dividend;
  logic                        div_start;
  tsp_pkg::div_stat_t          div_stat;
  logic [tsp_pkg::DataW-1:0]   quo;
  logic [tsp_pkg::DataW-1:0]   rem;
  logic [tsp_pkg::DataW-1:0]   clocks_ext;
  logic [tsp_pkg::DataW-1:0]   frac_carry;
  logic [41:0]                 prod_full;

  assign in_func  = s_axis_tuser;
  assign in_timer = s_axis_tdata[15:0];
  assign in_left  = s_axis_tdata[31:16];
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == tsp_pkg::ST_IDLE);

  // elapsed ticks; the 16-bit wrap covers the 65536 correction
  assign ticks    = auto_q ? period_q : (in_timer - prev_q);
  assign dividend = {{(tsp_pkg::DataW - tsp_pkg::TimerW - tsp_pkg::TickShift){1'b0}},
                     ticks, {tsp_pkg::TickShift{1'b0}}} + frac_q;

  assign clocks_ext = {{(tsp_pkg::DataW - tsp_pkg::CpsW){1'b0}}, clocks_q};
  // remainder plus the two dropped quotient bits times clocks
  assign frac_carry = rem
                    + (quo[0] ? clocks_ext : '0)
                    + (quo[1] ? {clocks_ext[tsp_pkg::DataW-2:0], 1'b0} : '0);
  assign prod_full  = left_q * clocks_q;

  // shared divider
  tsp_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (dividend),
    .divisor_i   (clocks_q),
    .stat_o      (div_stat),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    func_d      = func_q;
    timer_d     = timer_q;
    left_d      = left_q;
    prod_d      = prod_q;
    res_d       = res_q;
    prev_d      = prev_q;
    frac_d      = frac_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    div_start   = 1'b0;
    unique case (state_q)
      tsp_pkg::ST_IDLE: begin
        if (in_acc) begin
          func_d  = in_func;
          timer_d = in_timer;
          left_d  = in_left;
          res_d   = '0;
          state_d = tsp_pkg::ST_EMIT;
          if (active_q) begin
            priority if (in_func == tsp_pkg::FUNC_UPDATE ||
                         (in_func == tsp_pkg::FUNC_QUERY && !auto_q)) begin
              div_start = 1'b1;
              state_d   = tsp_pkg::ST_DIV;
            end else if (in_func == tsp_pkg::FUNC_LEFTOVER) begin
              state_d = tsp_pkg::ST_MUL;
            end else begin
              state_d = tsp_pkg::ST_EMIT;
            end
          end
        end
      end
      tsp_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = tsp_pkg::ST_EMIT;
          if (func_q == tsp_pkg::FUNC_UPDATE) begin
            res_d   = {quo[tsp_pkg::DataW-1:2], 2'b00};
            total_d = total_q + {quo[tsp_pkg::DataW-1:2], 2'b00};
            frac_d  = frac_carry;
            if (!auto_q) begin
              prev_d = timer_q;
            end
          end else begin
            res_d = total_q + quo;
          end
        end
      end
      tsp_pkg::ST_MUL: begin
        prod_d  = prod_full[tsp_pkg::DataW-1:0];
        state_d = tsp_pkg::ST_ACC;
      end
      tsp_pkg::ST_ACC: begin
        frac_d  = frac_q + prod_q;
        state_d = tsp_pkg::ST_EMIT;
      end
      tsp_pkg::ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = tsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsp_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      auto_q   <= 1'b0;
      period_q <= '0;
      clocks_q <= tsp_pkg::CLOCKS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tsp_pkg::REG_STREAM_ACTIVE: active_q <= cfg_data_i[0];
        tsp_pkg::REG_AUTO_MODE:     auto_q   <= cfg_data_i[0];
        tsp_pkg::REG_AUTO_PERIOD:   period_q <= cfg_data_i[tsp_pkg::TimerW-1:0];
        tsp_pkg::REG_CLOCKS:        clocks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tsp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
      frac_q      <= '0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      prev_q      <= prev_d;
      frac_q      <= frac_d;
      total_q     <= total_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    timer_q    <= timer_d;
    left_q     <= left_d;
    prod_q     <= prod_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // divider only runs for a request in the divide state
  `ASSERT_IMPL(a_div_owned, div_stat.busy, state_q == tsp_pkg::ST_DIV)
  // an active update request always starts the divider
  `ASSERT_NEXT(a_update_divides,
               in_acc && active_q && in_func == tsp_pkg::FUNC_UPDATE, div_stat.busy)
  // leaving the emit state presents a result
  `ASSERT_NEXT(a_emit_shows,
               state_q == tsp_pkg::ST_EMIT && state_d == tsp_pkg::ST_IDLE, m_axis_tvalid)

endmodule

// ===== rtl/core/tsp_div.sv =====
// ----------------------------------------------------------------------------
// tsp_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tsp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tsp_pkg::DataW-1:0]     dividend_i,
  input  logic [tsp_pkg::CpsW-1:0]      divisor_i,
  output tsp_pkg::div_stat_t            stat_o,
  output logic [tsp_pkg::DataW-1:0]     quotient_o,
  output logic [tsp_pkg::DataW-1:0]     remainder_o
);

  logic [tsp_pkg::DataW-1:0]   rem_q, rem_d;
  logic [tsp_pkg::DataW-1:0]   quo_q, quo_d;
  logic [tsp_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [tsp_pkg::DataW-1:0]   shifted;
  logic [tsp_pkg::DataW-1:0]   divisor_ext;
  logic                        fits;

  // one shift, compare and subtract step
  assign shifted     = {rem_q[tsp_pkg::DataW-2:0], quo_q[tsp_pkg::DataW-1]};
  assign divisor_ext = {{(tsp_pkg::DataW - tsp_pkg::CpsW){1'b0}}, divisor_i};
  assign fits        = (shifted >= divisor_ext);

  // step control
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      cnt_d  = tsp_pkg::DivCntW'(tsp_pkg::DivSteps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? (shifted - divisor_ext) : shifted;
      quo_d = {quo_q[tsp_pkg::DataW-2:0], fits};
      cnt_d = cnt_q - tsp_pkg::DivCntW'(1);
      if (cnt_q == tsp_pkg::DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule
